### rtl/core/sha_pkg.sv
// shared types and constants of the sha-256 byte stream hasher
// used by sha_round and sha256_byte_stream_hasher; no dependencies

package sha_pkg;

    // round variables a..h, also used for the chaining value
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } t_work;

    // standard initial chaining value
    localparam t_work HASH_IV = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

    // round constants
    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // padding bytes and buffer positions
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [7:0] PAD_ZERO    = 8'h00;
    localparam logic [5:0] PAD_LEN_POS = 6'd56;
    localparam logic [5:0] BLOCK_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST  = 6'd63;

endpackage

### rtl/core/sha_round.sv
// one sha-256 compression round plus one message schedule step
// depends on sha_pkg for the round variable struct

module sha_round (
    input  sha_pkg::t_work i_work,
    input  logic [31:0]    i_k,
    input  logic [31:0]    i_w0,
    input  logic [31:0]    i_w1,
    input  logic [31:0]    i_w9,
    input  logic [31:0]    i_w14,
    output sha_pkg::t_work o_work,
    output logic [31:0]    o_w_next
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] sum1;
    logic [31:0] sum0;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] tmp1;
    logic [31:0] tmp2;
    logic [31:0] sig0;
    logic [31:0] sig1;

    // round function
    always_comb begin
        sum1   = rotr(i_work.e, 6) ^ rotr(i_work.e, 11) ^ rotr(i_work.e, 25);
        choose = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        tmp1   = i_work.h + sum1 + choose + i_k + i_w0;
        sum0   = rotr(i_work.a, 2) ^ rotr(i_work.a, 13) ^ rotr(i_work.a, 22);
        major  = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);
        tmp2   = sum0 + major;
        o_work = '{
            a: tmp1 + tmp2, b: i_work.a, c: i_work.b, d: i_work.c,
            e: i_work.d + tmp1, f: i_work.e, g: i_work.f, h: i_work.g
        };
    end

    // schedule word sixteen rounds ahead
    always_comb begin
        sig1     = rotr(i_w14, 17) ^ rotr(i_w14, 19) ^ (i_w14 >> 10);
        sig0     = rotr(i_w1, 7) ^ rotr(i_w1, 18) ^ (i_w1 >> 3);
        o_w_next = sig1 + i_w9 + sig0 + i_w0;
    end

endmodule

### rtl/core/sha256_byte_stream_hasher.sv
// sha-256 hasher over a byte stream, top level with sequencer and digest output
// depends on sha_pkg and sha_round
//
// usage:
//   slave side takes one message byte per item in s_axis_tdata, s_axis_tlast
//   marks the last byte of a message. master side gives the digest as eight
//   32-bit big-endian words, H0 first, m_axis_tlast on the eighth word.
// sequence:
//   bytes are taken only while the sequencer is idle. each filled 64-byte
//   block runs through the shared round unit and then the chaining add, and
//   no byte is taken meanwhile. after the last byte the padding bytes go
//   through the byte path: the 0x80 mark, zeros, then the 64-bit bit length,
//   with an extra compression when 56 or more bytes were pending. then the
//   final compression runs and the digest is loaded into the output register;
//   the next message may start as soon as the digest is loaded.
// reset and stall:
//   reset restores the initial chaining value and empties the block and the
//   output register. a stalled receiver holds the digest words in place; the
//   core keeps hashing the next message and waits only to hand over its
//   digest while the previous one is still being drained.

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // digest_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } t_state;

    // where the sequencer resumes after a compression
    typedef enum logic [1:0] {
        CTX_IDLE,
        CTX_MARK,
        CTX_ZERO,
        CTX_DONE
    } t_ctx;

    t_state          r_state;
    t_ctx            r_ctx;
    logic [5:0]      r_fill;
    logic [5:0]      r_round;
    logic [60:0]     r_count;
    logic [63:0]     r_len;
    logic [511:0]    r_buf;
    sha_pkg::t_work  r_hash;
    sha_pkg::t_work  r_work;
    logic [31:0]     r_out_word [0:7];
    logic [2:0]      r_out_cnt;
    logic            r_out_valid;

    logic            ins;
    logic [7:0]      ins_byte;
    logic            out_take;
    sha_pkg::t_work  round_work;
    sha_pkg::t_work  hash_sum;
    logic [31:0]     w_next;

    // shared round unit, schedule taps at fixed places of the block shift line
    sha_round u_round (
        .i_work   (r_work),
        .i_k      (sha_pkg::ROUND_K[r_round]),
        .i_w0     (r_buf[511:480]),
        .i_w1     (r_buf[479:448]),
        .i_w9     (r_buf[223:192]),
        .i_w14    (r_buf[63:32]),
        .o_work   (round_work),
        .o_w_next (w_next)
    );

    // chaining add
    always_comb begin
        hash_sum = '{
            a: r_hash.a + r_work.a, b: r_hash.b + r_work.b,
            c: r_hash.c + r_work.c, d: r_hash.d + r_work.d,
            e: r_hash.e + r_work.e, f: r_hash.f + r_work.f,
            g: r_hash.g + r_work.g, h: r_hash.h + r_work.h
        };
    end

    // byte that enters the block this cycle
    always_comb begin
        ins      = 1'b0;
        ins_byte = s_axis_tdata;
        unique case (r_state)
            ST_IDLE: ins = s_axis_tvalid;
            ST_MARK: begin
                ins      = 1'b1;
                ins_byte = sha_pkg::PAD_MARK;
            end
            ST_ZERO: begin
                ins      = (r_fill != sha_pkg::PAD_LEN_POS);
                ins_byte = sha_pkg::PAD_ZERO;
            end
            ST_LEN: begin
                ins      = 1'b1;
                ins_byte = r_len[63:56];
            end
            default: ins = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_take      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word[0];
    assign m_axis_tlast  = (r_out_cnt == 3'd7);

    // sequencer, block shift line, round variables and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ctx       <= CTX_IDLE;
            r_fill      <= '0;
            r_round     <= '0;
            r_count     <= '0;
            r_hash      <= sha_pkg::HASH_IV;
            r_out_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ins) begin
                r_buf  <= {r_buf[503:0], ins_byte};
                r_fill <= r_fill + 6'd1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_count <= s_axis_tlast ? '0 : r_count + 61'd1;
                        if (s_axis_tlast) begin
                            r_len <= {r_count + 61'd1, 3'b000};
                        end
                        if (r_fill == sha_pkg::BLOCK_LAST) begin
                            r_state <= ST_ROUND;
                            r_work  <= r_hash;
                            r_ctx   <= s_axis_tlast ? CTX_MARK : CTX_IDLE;
                        end else if (s_axis_tlast) begin
                            r_state <= ST_MARK;
                        end
                    end
                end
                ST_MARK: begin
                    if (r_fill == sha_pkg::BLOCK_LAST) begin
                        r_state <= ST_ROUND;
                        r_work  <= r_hash;
                        r_ctx   <= CTX_ZERO;
                    end else begin
                        r_state <= ST_ZERO;
                    end
                end
                ST_ZERO: begin
                    if (r_fill == sha_pkg::PAD_LEN_POS) begin
                        r_state <= ST_LEN;
                    end else if (r_fill == sha_pkg::BLOCK_LAST) begin
                        r_state <= ST_ROUND;
                        r_work  <= r_hash;
                        r_ctx   <= CTX_ZERO;
                    end
                end
                ST_LEN: begin
                    r_len <= {r_len[55:0], 8'h00};
                    if (r_fill == sha_pkg::BLOCK_LAST) begin
                        r_state <= ST_ROUND;
                        r_work  <= r_hash;
                        r_ctx   <= CTX_DONE;
                    end
                end
                ST_ROUND: begin
                    r_work  <= round_work;
                    r_buf   <= {r_buf[479:0], w_next};
                    r_round <= r_round + 6'd1;
                    if (r_round == sha_pkg::ROUND_LAST) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_hash <= hash_sum;
                    unique case (r_ctx)
                        CTX_IDLE: r_state <= ST_IDLE;
                        CTX_MARK: r_state <= ST_MARK;
                        CTX_ZERO: r_state <= ST_ZERO;
                        CTX_DONE: r_state <= ST_DONE;
                        default:  r_state <= ST_IDLE;
                    endcase
                end
                ST_DONE: begin
                    // hand over the digest once the output register is free
                    if (!r_out_valid) begin
                        r_out_word[0] <= r_hash.a;
                        r_out_word[1] <= r_hash.b;
                        r_out_word[2] <= r_hash.c;
                        r_out_word[3] <= r_hash.d;
                        r_out_word[4] <= r_hash.e;
                        r_out_word[5] <= r_hash.f;
                        r_out_word[6] <= r_hash.g;
                        r_out_word[7] <= r_hash.h;
                        r_out_cnt     <= '0;
                        r_out_valid   <= 1'b1;
                        r_hash        <= sha_pkg::HASH_IV;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // drain digest words one item at a time
            if (out_take) begin
                for (int i = 0; i < 7; i++) begin
                    r_out_word[i] <= r_out_word[i + 1];
                end
                r_out_cnt <= r_out_cnt + 3'd1;
                if (r_out_cnt == 3'd7) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // round counter only runs during compression
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_round == 6'd0))
        else $error("round counter left nonzero outside compression");

    // a compression always starts on a full block
    a_round_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_fill == 6'd0))
        else $error("compression running on a partial block");

    // length bytes only fill the last eight positions of a block
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill >= sha_pkg::PAD_LEN_POS))
        else $error("length bytes placed before byte 56");

    // the digest register is loaded only when empty
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (r_out_valid && r_out_cnt == 3'd0))
        else $error("digest handover lost");

endmodule
